// ----- sv/dcre_pkg.sv -----
// Shared types and constants of the component remap engine.
package dcre_pkg;

    localparam int ADDR_BITS  = 40;
    localparam int COMP_W     = 32;
    localparam int NUM_COMP   = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 40;
    localparam int SWZ_W      = 3;

    // in tdata: four source components
    localparam int IN_TDATA_W  = NUM_COMP * COMP_W;
    // out tdata: address, four components, write mask, padded to bytes
    localparam int OUT_PAYLD_W = ADDR_BITS + NUM_COMP * COMP_W + NUM_COMP;
    localparam int OUT_TDATA_W = ((OUT_PAYLD_W + 7) / 8) * 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DST_BASE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DST_PITCH   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SWIZZLE     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_CONST_A     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_CONST_B     = CFG_IDX_W'(7);

    // swizzle codes for source w and the two constants
    localparam logic [SWZ_W-1:0] SWZ_SRC_W   = 3'd3;
    localparam logic [SWZ_W-1:0] SWZ_CONST_A = 3'd4;
    localparam logic [SWZ_W-1:0] SWZ_CONST_B = 3'd5;

    typedef logic [COMP_W-1:0] t_comp;

    typedef struct packed {
        logic [ADDR_BITS-1:0]      dst_base;
        logic [31:0]               dst_pitch;
        logic [31:0]               line_length;
        logic [31:0]               line_count;
        logic [NUM_COMP*SWZ_W-1:0] swizzle_codes;
        logic [5:0]                component_format;
        t_comp                     const_a;
        t_comp                     const_b;
    } t_cfg;

    // copy restart request from a geometry write
    typedef struct packed {
        logic                 restart;
        logic [ADDR_BITS-1:0] base;
    } t_restart;

endpackage

// ----- sv/dma_component_remap_engine_unit.sv -----
// Top level of the DMA component remap engine.
//
// Source elements arrive on the s_axis channel, four 32-bit components each.
// Each element gives one destination element on m_axis: byte address,
// four swizzled and size-truncated components, a write mask, end of line
// on tlast and end of copy on tuser. While line_length or line_count is
// zero, accepted items are dropped and give no result.
// Registers are written through the cfg channel, which is always ready;
// writing a geometry register restarts the copy at dst_base.
// An accepted item lands in the input register, and the select and address
// logic load the result register from it once the result register is free.
// Throughput is one item per cycle while the receiver takes every result.
// When the receiver stalls, the result register holds and the input register,
// if empty, still takes one more item before s_axis_tready drops.
// Reset clears the registers to their defaults (line_count one, the rest
// zero), the counters, and both valid flags.
module dma_component_remap_engine_unit
    import dcre_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // src_x, src_y, src_z, src_w
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // dst_addr, dst_x, dst_y, dst_z, dst_w, write_mask, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    // end_of_copy
    output logic                   m_axis_tuser
);

    t_cfg                 w_cfg;
    t_restart             w_restart;
    logic                 w_cfg_wr;

    logic                 r_in_valid;
    t_comp [NUM_COMP-1:0] r_src;

    logic                 r_out_valid;
    logic [ADDR_BITS-1:0] r_addr;
    t_comp [NUM_COMP-1:0] r_dst;
    logic [NUM_COMP-1:0]  r_mask;
    logic                 r_eol;
    logic                 r_eoc;

    logic                 w_adv;
    logic                 w_empty;
    logic                 w_emit;
    logic                 w_in_acc;
    logic [ADDR_BITS-1:0] w_addr;
    logic                 w_eol;
    logic                 w_eoc;
    t_comp [NUM_COMP-1:0] w_dst;
    logic [NUM_COMP-1:0]  w_mask;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    dcre_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_cfg_wr),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg),
        .o_restart  (w_restart)
    );

    // move the input register on when the result register is free
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_empty       = (w_cfg.line_length == 32'd0) || (w_cfg.line_count == 32'd0);
    assign w_emit        = r_in_valid && w_adv && !w_empty;

    dcre_addr_gen u_addr_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_restart (w_restart),
        .i_step    (w_emit),
        .o_addr    (w_addr),
        .o_eol     (w_eol),
        .o_eoc     (w_eoc)
    );

    dcre_swizzle u_swizzle (
        .i_cfg  (w_cfg),
        .i_src  (r_src),
        .o_dst  (w_dst),
        .o_mask (w_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int i = 0; i < NUM_COMP; i++) begin
                r_src[i] <= s_axis_tdata[i*COMP_W +: COMP_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_addr <= w_addr;
            r_dst  <= w_dst;
            r_mask <= w_mask;
            r_eol  <= w_eol;
            r_eoc  <= w_eoc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_PAYLD_W)'(0), r_mask,
                            r_dst[3], r_dst[2], r_dst[1], r_dst[0], r_addr};
    assign m_axis_tlast  = r_eol;
    assign m_axis_tuser  = r_eoc;

endmodule

// ----- sv/dcre_cfg.sv -----
// Configuration register file of the component remap engine.
module dcre_cfg
    import dcre_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg,
    output t_restart              o_restart
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        o_restart.restart = 1'b0;
        o_restart.base    = r_cfg.dst_base;
        if (i_wr_en) begin
            case (i_wr_index)
                REG_DST_BASE: begin
                    n_cfg.dst_base    = i_wr_data[ADDR_BITS-1:0];
                    o_restart.restart = 1'b1;
                    o_restart.base    = i_wr_data[ADDR_BITS-1:0];
                end
                REG_DST_PITCH: begin
                    n_cfg.dst_pitch   = i_wr_data[31:0];
                    o_restart.restart = 1'b1;
                end
                REG_LINE_LENGTH: begin
                    n_cfg.line_length = i_wr_data[31:0];
                    o_restart.restart = 1'b1;
                end
                REG_LINE_COUNT: begin
                    n_cfg.line_count  = i_wr_data[31:0];
                    o_restart.restart = 1'b1;
                end
                REG_SWIZZLE:  n_cfg.swizzle_codes    = i_wr_data[NUM_COMP*SWZ_W-1:0];
                REG_FORMAT:   n_cfg.component_format = i_wr_data[5:0];
                REG_CONST_A:  n_cfg.const_a          = i_wr_data[COMP_W-1:0];
                REG_CONST_B:  n_cfg.const_b          = i_wr_data[COMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{line_count: 32'd1, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/dcre_addr_gen.sv -----
// Element and line counters and destination address generation.
module dcre_addr_gen
    import dcre_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_restart             i_restart,
    input  logic                 i_step,
    output logic [ADDR_BITS-1:0] o_addr,
    output logic                 o_eol,
    output logic                 o_eoc
);

    logic [31:0]          r_elem_idx;
    logic [31:0]          r_line_idx;
    logic [ADDR_BITS-1:0] r_line_base;

    logic [2:0]  w_comp_bytes;
    logic [2:0]  w_dst_count;
    logic [4:0]  w_bpe;
    logic [36:0] w_offset;

    assign w_comp_bytes = {1'b0, i_cfg.component_format[1:0]} + 3'd1;
    assign w_dst_count  = {1'b0, i_cfg.component_format[5:4]} + 3'd1;
    assign w_bpe        = 5'({2'b00, w_comp_bytes} * {2'b00, w_dst_count});
    assign w_offset     = {5'd0, r_elem_idx} * {32'd0, w_bpe};

    assign o_addr = r_line_base + ADDR_BITS'(w_offset);
    assign o_eol  = r_elem_idx >= (i_cfg.line_length - 32'd1);
    assign o_eoc  = o_eol && (r_line_idx >= (i_cfg.line_count - 32'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_idx  <= '0;
            r_line_idx  <= '0;
            r_line_base <= '0;
        end else if (i_restart.restart) begin
            r_elem_idx  <= '0;
            r_line_idx  <= '0;
            r_line_base <= i_restart.base;
        end else if (i_step) begin
            if (o_eoc) begin
                r_elem_idx  <= '0;
                r_line_idx  <= '0;
                r_line_base <= i_cfg.dst_base;
            end else if (o_eol) begin
                r_elem_idx  <= '0;
                r_line_idx  <= r_line_idx + 32'd1;
                r_line_base <= r_line_base + ADDR_BITS'(i_cfg.dst_pitch);
            end else begin
                r_elem_idx  <= r_elem_idx + 32'd1;
            end
        end
    end

endmodule

// ----- sv/dcre_swizzle.sv -----
// Per-component swizzle select, size truncation and write mask.
module dcre_swizzle
    import dcre_pkg::*;
(
    input  t_cfg                i_cfg,
    input  t_comp [NUM_COMP-1:0] i_src,
    output t_comp [NUM_COMP-1:0] o_dst,
    output logic [NUM_COMP-1:0] o_mask
);

    t_comp      w_vmask;
    logic [2:0] w_src_count;
    logic [2:0] w_dst_count;

    assign w_src_count = {1'b0, i_cfg.component_format[3:2]} + 3'd1;
    assign w_dst_count = {1'b0, i_cfg.component_format[5:4]} + 3'd1;

    always_comb begin
        case (i_cfg.component_format[1:0])
            2'd0:    w_vmask = 32'h0000_00FF;
            2'd1:    w_vmask = 32'h0000_FFFF;
            2'd2:    w_vmask = 32'h00FF_FFFF;
            default: w_vmask = 32'hFFFF_FFFF;
        endcase
    end

    always_comb begin
        logic [SWZ_W-1:0] code;
        t_comp            val;
        logic             wr;
        for (int i = 0; i < NUM_COMP; i++) begin
            code = i_cfg.swizzle_codes[i*SWZ_W +: SWZ_W];
            val  = '0;
            wr   = 1'b1;
            if (3'(i) >= w_dst_count) begin
                wr = 1'b0;
            end else if (code <= SWZ_SRC_W) begin
                // source components past the source count read as zero
                if (code < w_src_count) begin
                    val = i_src[code[1:0]];
                end
            end else if (code == SWZ_CONST_A) begin
                val = i_cfg.const_a;
            end else if (code == SWZ_CONST_B) begin
                val = i_cfg.const_b;
            end else begin
                wr = 1'b0;
            end
            o_dst[i]  = wr ? (val & w_vmask) : '0;
            o_mask[i] = wr;
        end
    end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the DMA component remap engine unit.
`timescale 1ns / 100ps

module tb;
    import dcre_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 450;
    localparam int NUM_REGS      = 8;
    localparam int GAP_PERCENT   = 23;

    // swizzle codes not named in the package
    localparam logic [SWZ_W-1:0] SWZ_SRC_X    = 3'd0;
    localparam logic [SWZ_W-1:0] SWZ_SRC_Y    = 3'd1;
    localparam logic [SWZ_W-1:0] SWZ_SRC_Z    = 3'd2;
    localparam logic [SWZ_W-1:0] SWZ_SKIP     = 3'd6;
    localparam logic [SWZ_W-1:0] SWZ_SKIP_ALT = 3'd7;

    typedef t_comp [NUM_COMP-1:0] t_src_elem;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        t_comp [NUM_COMP-1:0] comp;
        logic [NUM_COMP-1:0]  wmask;
        logic                 eol;
        logic                 eoc;
    } t_dst_elem;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    dma_component_remap_engine_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow registers and copy walk of the predictor
    t_cfg                 reg_file;
    logic [31:0]          elem_pos;
    logic [31:0]          line_pos;
    logic [ADDR_BITS-1:0] line_addr;

    t_src_elem src_backlog[$];
    t_dst_elem pending_dst[$];

    bit steady = 1'b0;
    int n_fail = 0;
    int n_src_accepted = 0;
    int n_dropped = 0;
    int n_checked = 0;
    int n_reg_writes = 0;
    int n_phases = 0;

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < GAP_PERCENT);
    endfunction

    function automatic t_comp rand_word();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return '0;
        if (r < 30)
            return '1;
        return $urandom();
    endfunction

    function automatic t_src_elem rand_src();
        t_src_elem s;
        for (int i = 0; i < NUM_COMP; i++)
            s[i] = rand_word();
        return s;
    endfunction

    function automatic void restart_copy();
        elem_pos  = '0;
        line_pos  = '0;
        line_addr = reg_file.dst_base;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DST_BASE: begin
                reg_file.dst_base = data[ADDR_BITS-1:0];
                restart_copy();
            end
            REG_DST_PITCH: begin
                reg_file.dst_pitch = data[31:0];
                restart_copy();
            end
            REG_LINE_LENGTH: begin
                reg_file.line_length = data[31:0];
                restart_copy();
            end
            REG_LINE_COUNT: begin
                reg_file.line_count = data[31:0];
                restart_copy();
            end
            REG_SWIZZLE: reg_file.swizzle_codes = data[NUM_COMP*SWZ_W-1:0];
            REG_FORMAT:  reg_file.component_format = data[5:0];
            REG_CONST_A: reg_file.const_a = data[COMP_W-1:0];
            REG_CONST_B: reg_file.const_b = data[COMP_W-1:0];
            default: ;
        endcase
    endfunction

    // Build the destination element for one source element and advance the walk.
    // Returns 0 when the geometry is empty and the item is dropped.
    function automatic bit remap_element(input t_src_elem src, output t_dst_elem res);
        int unsigned      nbytes, nsrc, ndst;
        logic [SWZ_W-1:0] code;
        t_comp            keep, v;
        logic [63:0]      sum;
        bit               wr;
        res = '0;
        if (reg_file.line_length == 0 || reg_file.line_count == 0)
            return 1'b0;
        nbytes = reg_file.component_format[1:0] + 1;
        nsrc   = reg_file.component_format[3:2] + 1;
        ndst   = reg_file.component_format[5:4] + 1;
        keep   = {COMP_W{1'b1}} >> (COMP_W - 8 * nbytes);
        sum    = 64'(line_addr) + 64'(elem_pos) * 64'(ndst * nbytes);
        res.addr = sum[ADDR_BITS-1:0];
        for (int i = 0; i < NUM_COMP; i++) begin
            code = reg_file.swizzle_codes[SWZ_W*i +: SWZ_W];
            wr = 1'b1;
            v  = '0;
            if (i >= ndst)
                wr = 1'b0;
            else if (code <= SWZ_SRC_W)
                v = (code < nsrc) ? src[code] : '0;
            else if (code == SWZ_CONST_A)
                v = reg_file.const_a;
            else if (code == SWZ_CONST_B)
                v = reg_file.const_b;
            else
                wr = 1'b0;
            res.comp[i]  = wr ? (v & keep) : '0;
            res.wmask[i] = wr;
        end
        res.eol = elem_pos >= reg_file.line_length - 32'd1;
        res.eoc = res.eol && (line_pos >= reg_file.line_count - 32'd1);
        if (res.eoc) begin
            restart_copy();
        end else if (res.eol) begin
            elem_pos  = '0;
            line_pos  = line_pos + 32'd1;
            line_addr = line_addr + reg_file.dst_pitch;
        end else begin
            elem_pos = elem_pos + 32'd1;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    // source side: hold the item until taken, then load the next one
    always @(posedge i_clk) begin : src_drive
        t_dst_elem want;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                n_src_accepted++;
                if (remap_element(s_axis_tdata, want))
                    pending_dst.push_back(want);
                else
                    n_dropped++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_backlog.size() != 0 && !take_gap()) begin
                    s_axis_tdata  <= src_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each taken item with the oldest expectation
    always @(posedge i_clk) begin : dst_watch
        t_dst_elem  want;
        string      comp_name[NUM_COMP];
        comp_name = '{"dst_x", "dst_y", "dst_z", "dst_w"};
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_dst.size() == 0) begin
                    $error("result item with no expectation waiting");
                    n_fail++;
                end else begin
                    want = pending_dst.pop_front();
                    n_checked++;
                    check_field("dst_addr", want.addr, m_axis_tdata[ADDR_BITS-1:0]);
                    for (int i = 0; i < NUM_COMP; i++)
                        check_field(comp_name[i], want.comp[i],
                                    m_axis_tdata[ADDR_BITS + i*COMP_W +: COMP_W]);
                    check_field("write_mask", want.wmask,
                                m_axis_tdata[ADDR_BITS + NUM_COMP*COMP_W +: NUM_COMP]);
                    check_field("end_of_line", want.eol, m_axis_tlast);
                    check_field("end_of_copy", want.eoc, m_axis_tuser);
                end
            end
            m_axis_tready <= !take_gap();
        end
    end

    // wait for every item to be taken and every result to arrive
    task automatic drain();
        do @(posedge i_clk);
        while (src_backlog.size() != 0 || s_axis_tvalid || pending_dst.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        apply_reg(idx, data);
        n_reg_writes++;
    endtask

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int          n, r, n_random;
        logic [63:0] wide;
        reg_file = '0;
        reg_file.line_count = 32'd1;
        restart_copy();
        n_random = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry has zero line length: items are dropped
        src_backlog.push_back('1);
        src_backlog.push_back('0);
        drain();

        // straight copy, address wraps at the top of the space
        write_reg(REG_DST_BASE, 40'hFF_FFFF_FFF8);
        write_reg(REG_DST_PITCH, {8'h5A, 32'hFFFF_FFFF});
        write_reg(REG_LINE_LENGTH, 40'd2);
        write_reg(REG_LINE_COUNT, 40'd2);
        write_reg(REG_SWIZZLE,
                  CFG_DATA_W'({SWZ_SRC_W, SWZ_SRC_Z, SWZ_SRC_Y, SWZ_SRC_X}));
        write_reg(REG_FORMAT, CFG_DATA_W'({2'd3, 2'd3, 2'd3}));
        write_reg(REG_CONST_A, {8'hC3, 32'hFFFF_FFFF});
        write_reg(REG_CONST_B, 40'h8000_0001);
        i_cfg_valid <= 1'b0;
        src_backlog.push_back('1);
        src_backlog.push_back('0);
        repeat (3) src_backlog.push_back(rand_src());
        drain();

        // constants and no-write codes, byte components; copy keeps walking
        write_reg(REG_SWIZZLE,
                  CFG_DATA_W'({SWZ_SKIP_ALT, SWZ_SKIP, SWZ_CONST_B, SWZ_CONST_A}));
        write_reg(REG_FORMAT, CFG_DATA_W'({2'd3, 2'd0, 2'd0}));
        i_cfg_valid <= 1'b0;
        repeat (3) src_backlog.push_back(rand_src());
        drain();

        // sources past the source count, w past the destination count,
        // zero line count drops items, unused index is ignored
        write_reg(REG_SWIZZLE,
                  CFG_DATA_W'({SWZ_SRC_X, SWZ_SRC_Y, SWZ_SRC_Z, SWZ_SRC_W}));
        write_reg(REG_FORMAT, CFG_DATA_W'({2'd2, 2'd1, 2'd1}));
        write_reg(REG_LINE_COUNT, 40'd0);
        write_reg(CFG_IDX_W'(NUM_REGS), '1);
        i_cfg_valid <= 1'b0;
        src_backlog.push_back('1);
        src_backlog.push_back(rand_src());
        drain();

        // one element per line, three lines, then a new copy
        write_reg(REG_LINE_COUNT, 40'd3);
        write_reg(REG_LINE_LENGTH, 40'd1);
        write_reg(REG_DST_BASE, 40'd0);
        write_reg(REG_DST_PITCH, 40'h100);
        i_cfg_valid <= 1'b0;
        repeat (4) src_backlog.push_back(rand_src());
        drain();

        // largest geometry, three-byte components
        write_reg(REG_LINE_LENGTH, {8'h01, 32'hFFFF_FFFF});
        write_reg(REG_LINE_COUNT, 40'hFFFF_FFFF);
        write_reg(REG_DST_PITCH, 40'd0);
        write_reg(REG_FORMAT, CFG_DATA_W'({2'd0, 2'd3, 2'd2}));
        i_cfg_valid <= 1'b0;
        src_backlog.push_back('1);
        src_backlog.push_back(rand_src());
        drain();

        // random phases: mostly short lines and few lines so copies end often
        while (n_random < RANDOM_ITEMS) begin
            n_phases++;
            if ($urandom_range(1)) begin
                r = $urandom_range(9);
                wide = {$urandom(), $urandom()};
                write_reg(REG_DST_BASE, (r == 0) ? {CFG_DATA_W{1'b1}} :
                                        (r == 1) ? '0 : CFG_DATA_W'(wide));
            end
            if ($urandom_range(1))
                write_reg(REG_DST_PITCH, {8'($urandom_range(255)), rand_word()});
            if ($urandom_range(1)) begin
                r = $urandom_range(19);
                write_reg(REG_LINE_LENGTH, (r < 2) ? 40'd0 :
                                           (r == 2) ? 40'hFFFF_FFFF :
                                           CFG_DATA_W'($urandom_range(1, 8)));
            end
            if ($urandom_range(1)) begin
                r = $urandom_range(24);
                write_reg(REG_LINE_COUNT, (r < 2) ? {8'($urandom_range(255)), 32'd0} :
                                          (r == 2) ? 40'hFFFF_FFFF :
                                          CFG_DATA_W'($urandom_range(1, 4)));
            end
            if ($urandom_range(3) != 0) begin
                wide = {$urandom(), $urandom()};
                write_reg(REG_SWIZZLE, CFG_DATA_W'(wide));
            end
            if ($urandom_range(3) != 0) begin
                wide = {$urandom(), $urandom()};
                write_reg(REG_FORMAT, CFG_DATA_W'(wide));
            end
            if ($urandom_range(1))
                write_reg(REG_CONST_A, {8'($urandom_range(255)), rand_word()});
            if ($urandom_range(1))
                write_reg(REG_CONST_B, {8'($urandom_range(255)), rand_word()});
            if ($urandom_range(9) == 0)
                write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1)),
                          CFG_DATA_W'($urandom()));
            i_cfg_valid <= 1'b0;
            // one long phase runs with both sides at full rate
            steady <= (n_phases == 4);
            n = (n_phases == 4) ? 80 : $urandom_range(8, 40);
            repeat (n) src_backlog.push_back(rand_src());
            if (reg_file.line_length != 0 && reg_file.line_count != 0)
                n_random += n;
            drain();
        end

        $display("covered %0d source items (%0d dropped on empty geometry), %0d results checked",
                 n_src_accepted, n_dropped, n_checked);
        $display("applied %0d register writes over %0d random setups plus directed cases",
                 n_reg_writes, n_phases);
        if (n_fail == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
